// ----- rtl/nearest_palette_color_search_defines.svh -----
// Assertion macros shared by the RTL.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
`define NPCS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define NPCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NPCS_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define NPCS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/npcs_pkg.sv -----
package npcs_pkg;

  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned IdxW           = 8;
  localparam int unsigned CountW         = 9;
  localparam int unsigned DistW          = 18;
  localparam int unsigned SqW            = 16;
  localparam logic [DistW-1:0] MaxDist   = 18'd260100;

  typedef enum logic {
    OpWrite = 1'b0,
    OpMap   = 1'b1
  } op_e;

  typedef enum logic {
    RegPaletteCount = 1'b0,
    RegUseAlpha     = 1'b1
  } reg_e;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] idx;
    rgba_t           pix;
    logic [IdxW-1:0] best_idx;
    logic [DistW-1:0] best_dist;
    logic [DistW-1:0] cand_dist;
  } stage_t;

  function automatic logic [SqW-1:0] sq_diff(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] d;
    d = (x > y) ? (x - y) : (y - x);
    return 16'(d) * 16'(d);
  endfunction

  function automatic logic [DistW-1:0] distance(input rgba_t e, input rgba_t p,
                                                input logic use_alpha);
    logic [DistW-1:0] sum;
    sum = 18'(sq_diff(e.red, p.red)) + 18'(sq_diff(e.green, p.green))
        + 18'(sq_diff(e.blue, p.blue));
    if (use_alpha) begin
      sum = sum + 18'(sq_diff(e.alpha, p.alpha));
    end
    return sum;
  endfunction

  // Fold the distance of entry j into the running best.
  function automatic stage_t fold_best(input stage_t s, input logic [IdxW-1:0] j,
                                       input logic [CountW-1:0] count);
    stage_t r;
    r = s;
    if ((j == '0) || ((9'(j) < count) && (s.cand_dist < s.best_dist))) begin
      r.best_idx  = j;
      r.best_dist = s.cand_dist;
    end
    return r;
  endfunction

endpackage

// ----- rtl/npcs_cell.sv -----
module npcs_cell #(
  parameter int unsigned ENTRY_IDX = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [npcs_pkg::CountW-1:0]   count_i,
  input  logic                          use_alpha_i,
  input  logic                          valid_i,
  input  npcs_pkg::stage_t              stage_i,
  output logic                          valid_o,
  output npcs_pkg::stage_t              stage_o
);

  localparam logic [npcs_pkg::IdxW-1:0] EntryIdx = 8'(ENTRY_IDX);
  localparam logic [npcs_pkg::IdxW-1:0] PrevIdx  = 8'(ENTRY_IDX - 1);

  npcs_pkg::rgba_t  entry_q, entry_d;
  npcs_pkg::stage_t stage_q, stage_d;
  logic             valid_q;

  always_comb begin
    entry_d = entry_q;
    if (valid_i && (stage_i.op == npcs_pkg::OpWrite) && (stage_i.idx == EntryIdx)) begin
      entry_d = stage_i.pix;
    end
  end

  always_comb begin
    stage_d = stage_i;
    if (ENTRY_IDX != 0) begin
      stage_d = npcs_pkg::fold_best(stage_i, PrevIdx, count_i);
    end
    stage_d.cand_dist = npcs_pkg::distance(entry_q, stage_i.pix, use_alpha_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
      entry_q <= entry_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ----- rtl/npcs_out.sv -----
module npcs_out #(
  parameter int unsigned PALETTE_ENTRIES = npcs_pkg::PaletteEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [npcs_pkg::CountW-1:0]   count_i,
  input  logic                          valid_i,
  input  npcs_pkg::stage_t              stage_i,
  input  logic                          out_ready_i,
  output logic                          en_o,
  output logic                          out_valid_o,
  output logic [npcs_pkg::IdxW-1:0]     best_index_o,
  output logic [npcs_pkg::DistW-1:0]    best_distance_o
);

  localparam logic [npcs_pkg::IdxW-1:0] LastIdx = 8'(PALETTE_ENTRIES - 1);

  npcs_pkg::stage_t              fin;
  logic                          out_valid_q, out_valid_d;
  logic [npcs_pkg::IdxW-1:0]     best_index_q;
  logic [npcs_pkg::DistW-1:0]    best_distance_q;

  assign en_o        = !out_valid_q || out_ready_i;
  assign fin         = npcs_pkg::fold_best(stage_i, LastIdx, count_i);
  assign out_valid_d = valid_i && (stage_i.op == npcs_pkg::OpMap);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_o) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      best_index_q    <= fin.best_idx;
      best_distance_q <= fin.best_dist;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign best_index_o    = best_index_q;
  assign best_distance_o = best_distance_q;

endmodule

// ----- rtl/nearest_palette_color_search.sv -----
// Nearest palette colour search.
// Input channel (in_valid_i/in_ready_o) carries one word per item: a palette
// write (operation 0) loads entry entry_index with the RGBA fields, a map
// (operation 1) searches the palette for the RGBA pixel.
// Output channel (out_valid_o/out_ready_i) returns one word per map item:
// the index of the nearest entry (lowest index on a tie) and its squared
// distance. Writes give no output word.
// Every palette entry sits in its own pipeline cell; a word walks through
// PALETTE_ENTRIES cells and one output register, and one word is taken
// every cycle unless the receiver stalls the output. Writes and maps
// travel in order through the cells, so a map sees exactly the writes
// accepted before it.
// palette_count (address 0) and use_alpha (address 4) must be written over
// the APB port while the pipeline is empty; the block does not enforce it.
// Reset clears the valid bits, palette_count to 1 and use_alpha to 0;
// palette entries hold nothing until written.
// When the receiver stalls, the whole pipeline holds and in_ready_o drops.
`include "nearest_palette_color_search_defines.svh"

module nearest_palette_color_search #(
  parameter int unsigned PALETTE_ENTRIES = npcs_pkg::PaletteEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [npcs_pkg::IdxW-1:0]     entry_index_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic [7:0]                    alpha_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [npcs_pkg::IdxW-1:0]     best_index_o,
  output logic [npcs_pkg::DistW-1:0]    best_distance_o
);

  logic [npcs_pkg::CountW-1:0] count_q, count_d;
  logic                        use_alpha_q, use_alpha_d;
  logic                        cfg_wr;
  npcs_pkg::reg_e              reg_sel;

  logic                        pipe_en;
  logic [PALETTE_ENTRIES:0]    vld;
  npcs_pkg::stage_t            stg [PALETTE_ENTRIES+1];

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = npcs_pkg::reg_e'(paddr[2]);

  always_comb begin
    count_d     = count_q;
    use_alpha_d = use_alpha_q;
    if (cfg_wr) begin
      case (reg_sel)
        npcs_pkg::RegPaletteCount: count_d     = pwdata[npcs_pkg::CountW-1:0];
        npcs_pkg::RegUseAlpha:     use_alpha_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      npcs_pkg::RegPaletteCount: prdata = 32'(count_q);
      npcs_pkg::RegUseAlpha:     prdata = 32'(use_alpha_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= 9'd1;
      use_alpha_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      use_alpha_q <= use_alpha_d;
    end
  end

  assign in_ready_o = pipe_en;
  assign vld[0]     = in_valid_i;

  always_comb begin
    stg[0]           = '0;
    stg[0].op        = npcs_pkg::op_e'(operation_i);
    stg[0].idx       = entry_index_i;
    stg[0].pix.red   = red_i;
    stg[0].pix.green = green_i;
    stg[0].pix.blue  = blue_i;
    stg[0].pix.alpha = alpha_i;
  end

  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    npcs_cell #(
      .ENTRY_IDX(k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (pipe_en),
      .count_i    (count_q),
      .use_alpha_i(use_alpha_q),
      .valid_i    (vld[k]),
      .stage_i    (stg[k]),
      .valid_o    (vld[k+1]),
      .stage_o    (stg[k+1])
    );
  end

  npcs_out #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .count_i        (count_q),
    .valid_i        (vld[PALETTE_ENTRIES]),
    .stage_i        (stg[PALETTE_ENTRIES]),
    .out_ready_i    (out_ready_i),
    .en_o           (pipe_en),
    .out_valid_o    (out_valid_o),
    .best_index_o   (best_index_o),
    .best_distance_o(best_distance_o)
  );

  `NPCS_ASSERT_NEXT(a_stall_holds_pipe, !pipe_en, $stable(vld[PALETTE_ENTRIES:1]) && out_valid_o, "pipeline moved while stalled")
  `NPCS_ASSERT_IMPLIES(a_dist_range, out_valid_o, best_distance_o <= npcs_pkg::MaxDist, "distance out of range")
  `NPCS_ASSERT_IMPLIES(a_index_range, out_valid_o, 9'(best_index_o) < 9'(PALETTE_ENTRIES), "index beyond palette")

endmodule

// ----- tb/nearest_palette_color_search_tb.sv -----
module nearest_palette_color_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PaletteEntries = npcs_pkg::PaletteEntries;
  localparam int unsigned IdxW           = npcs_pkg::IdxW;
  localparam int unsigned CountW         = npcs_pkg::CountW;
  localparam int unsigned DistW          = npcs_pkg::DistW;

  localparam int unsigned DrainCycles = PaletteEntries + 45;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned PhaseWords  = 90;
  localparam int unsigned HoldWords   = 350;
  localparam int unsigned HoldPhase   = 5;
  localparam int unsigned PhaseTotal  = 7;

  typedef struct packed {
    logic [IdxW-1:0]  best_index;
    logic [DistW-1:0] best_distance;
  } match_t;

  typedef struct packed {
    logic              is_reg;
    npcs_pkg::reg_e    reg_sel;
    logic [CountW-1:0] reg_val;
    npcs_pkg::op_e     op;
    logic [IdxW-1:0]   idx;
    npcs_pkg::rgba_t   pix;
    logic              typed;
    match_t            want;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              operation_i;
  logic [IdxW-1:0]   entry_index_i;
  logic [7:0]        red_i;
  logic [7:0]        green_i;
  logic [7:0]        blue_i;
  logic [7:0]        alpha_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [IdxW-1:0]   best_index_o;
  logic [DistW-1:0]  best_distance_o;

  npcs_pkg::rgba_t   palette_shadow [PaletteEntries];
  logic [CountW-1:0] count_shadow = CountW'(1);
  logic              alpha_shadow = 1'b0;
  match_t            pending_matches [$];
  stim_row_t         stim_rows [$];
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;
  int unsigned       send_gap_pct = 0;
  int unsigned       recv_gap_pct = 0;
  bit                hold_request = 1'b0;

  nearest_palette_color_search DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .entry_index_i  (entry_index_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .alpha_i        (alpha_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .best_index_o   (best_index_o),
    .best_distance_o(best_distance_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned searched_entries();
    if (count_shadow == 0) return 1;
    if (count_shadow > PaletteEntries) return PaletteEntries;
    return count_shadow;
  endfunction

  function automatic match_t nearest_entry(input npcs_pkg::rgba_t px);
    match_t      best;
    int          dr, dg, db, da;
    int unsigned d;
    best = '0;
    for (int unsigned i = 0; i < searched_entries(); i++) begin
      dr = int'(palette_shadow[i].red) - int'(px.red);
      dg = int'(palette_shadow[i].green) - int'(px.green);
      db = int'(palette_shadow[i].blue) - int'(px.blue);
      da = int'(palette_shadow[i].alpha) - int'(px.alpha);
      d = dr * dr + dg * dg + db * db;
      if (alpha_shadow) d += da * da;
      if (i == 0 || d < best.best_distance) begin
        best.best_index    = IdxW'(i);
        best.best_distance = DistW'(d);
      end
    end
    return best;
  endfunction

  function automatic stim_row_t word_row(input npcs_pkg::op_e op,
                                         input logic [IdxW-1:0] idx,
                                         input logic [7:0] r, g, b, a);
    stim_row_t row;
    row       = '0;
    row.op    = op;
    row.idx   = idx;
    row.pix   = npcs_pkg::rgba_t'({a, b, g, r});
    return row;
  endfunction

  function automatic stim_row_t map_row(input logic [7:0] r, g, b, a,
                                        input logic [IdxW-1:0] ei,
                                        input logic [DistW-1:0] ed);
    stim_row_t row;
    row                    = word_row(npcs_pkg::OpMap, '0, r, g, b, a);
    row.typed              = 1'b1;
    row.want.best_index    = ei;
    row.want.best_distance = ed;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input npcs_pkg::reg_e sel,
                                        input logic [CountW-1:0] val);
    stim_row_t row;
    row         = '0;
    row.is_reg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  function automatic void add_row(input stim_row_t row);
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  task automatic check_reg(input npcs_pkg::reg_e sel, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d expected %0d actual %0d", $time, sel, want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_reg(input npcs_pkg::reg_e sel, input logic [CountW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == npcs_pkg::RegPaletteCount) count_shadow = val;
    else alpha_shadow = val[0];
    check_reg(sel, (sel == npcs_pkg::RegPaletteCount) ? 32'(val) : 32'(val[0]));
  endtask

  task automatic push_word(input npcs_pkg::op_e op, input logic [IdxW-1:0] idx,
                           input npcs_pkg::rgba_t pix, input logic typed,
                           input match_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    entry_index_i <= idx;
    red_i         <= pix.red;
    green_i       <= pix.green;
    blue_i        <= pix.blue;
    alpha_i       <= pix.alpha;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == npcs_pkg::OpWrite) palette_shadow[idx] = pix;
    else pending_matches.insert(pending_matches.size(), typed ? want : nearest_entry(pix));
  endtask

  // drop valid, then let in-flight palette writes drain as well
  task automatic await_idle();
    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned hold_left;
    match_t      want;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_matches.size() == 0) begin
          $display("%0t: word with no match pending, index %0d distance %0d",
                   $time, best_index_o, best_distance_o);
          mismatches++;
        end else begin
          want = pending_matches.pop_front();
          if (best_index_o !== want.best_index) begin
            $display("%0t: best_index expected %0d actual %0d",
                     $time, want.best_index, best_index_o);
            mismatches++;
          end
          if (best_distance_o !== want.best_distance) begin
            $display("%0t: best_distance expected %0d actual %0d",
                     $time, want.best_distance, best_distance_o);
            mismatches++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    npcs_pkg::rgba_t   pix;
    logic [CountW-1:0] cfg_count;
    logic              cfg_alpha;
    int unsigned       words;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid_i    <= 1'b0;
    operation_i   <= 1'b0;
    entry_index_i <= '0;
    red_i         <= '0;
    green_i       <= '0;
    blue_i        <= '0;
    alpha_i       <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reg(npcs_pkg::RegPaletteCount, 32'd1);
    check_reg(npcs_pkg::RegUseAlpha, 32'd0);

    add_row(word_row(npcs_pkg::OpWrite, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    add_row(map_row(8'hff, 8'hff, 8'hff, 8'hff, 8'd0, 18'd195075));
    add_row(map_row(8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 18'd0));
    add_row(word_row(npcs_pkg::OpWrite, 8'd1, 8'hff, 8'hff, 8'hff, 8'hff));
    add_row(word_row(npcs_pkg::OpWrite, 8'd2, 8'hff, 8'hff, 8'hff, 8'hff));
    add_row(word_row(npcs_pkg::OpWrite, 8'd255, 8'h80, 8'h7f, 8'h55, 8'haa));
    add_row(word_row(npcs_pkg::OpWrite, 8'd3, 8'h12, 8'h34, 8'h56, 8'h78));
    add_row(reg_row(npcs_pkg::RegPaletteCount, 9'd3));
    add_row(map_row(8'hff, 8'hff, 8'hff, 8'h00, 8'd1, 18'd0));
    add_row(reg_row(npcs_pkg::RegUseAlpha, 9'd1));
    add_row(map_row(8'hff, 8'hff, 8'hff, 8'h00, 8'd1, 18'd65025));
    add_row(map_row(8'h00, 8'h00, 8'h00, 8'hff, 8'd0, 18'd65025));
    add_row(reg_row(npcs_pkg::RegPaletteCount, 9'd0));
    add_row(map_row(8'hff, 8'hff, 8'hff, 8'hff, 8'd0, 18'd260100));
    add_row(reg_row(npcs_pkg::RegPaletteCount, 9'd4));
    add_row(map_row(8'h12, 8'h34, 8'h56, 8'h78, 8'd3, 18'd0));
    add_row(word_row(npcs_pkg::OpMap, 8'hff, 8'd100, 8'd150, 8'd200, 8'd50));
    add_row(reg_row(npcs_pkg::RegUseAlpha, 9'd0));
    add_row(map_row(8'h12, 8'h34, 8'h56, 8'h00, 8'd3, 18'd0));
    add_row(word_row(npcs_pkg::OpMap, 8'h00, 8'd1, 8'd2, 8'd3, 8'd4));
    add_row(word_row(npcs_pkg::OpWrite, 8'd0, 8'h12, 8'h34, 8'h56, 8'h78));
    add_row(map_row(8'h12, 8'h34, 8'h56, 8'h78, 8'd0, 18'd0));

    send_gap_pct = 38;
    recv_gap_pct = 88;
    foreach (stim_rows[k]) begin
      if (stim_rows[k].is_reg) begin
        await_idle();
        set_reg(stim_rows[k].reg_sel, stim_rows[k].reg_val);
      end else begin
        push_word(stim_rows[k].op, stim_rows[k].idx, stim_rows[k].pix,
                  stim_rows[k].typed, stim_rows[k].want);
      end
    end

    // load the whole palette so that any count is safe to search
    for (int unsigned i = 0; i < PaletteEntries; i++) begin
      push_word(npcs_pkg::OpWrite, IdxW'(i), npcs_pkg::rgba_t'($urandom()), 1'b0, '0);
    end

    for (int unsigned phase = 0; phase < PhaseTotal; phase++) begin
      case (phase)
        0: begin cfg_count = 9'd256; cfg_alpha = 1'b0; end
        1: begin cfg_count = 9'd511; cfg_alpha = 1'b1; end
        2: begin cfg_count = 9'd0;   cfg_alpha = 1'b1; end
        3: begin cfg_count = CountW'($urandom_range(40, 2)); cfg_alpha = 1'b0; end
        HoldPhase: begin cfg_count = 9'd256; cfg_alpha = 1'b1; end
        default: begin
          cfg_count = CountW'($urandom_range(511));
          cfg_alpha = 1'($urandom_range(1));
        end
      endcase
      if (phase < 2) begin
        send_gap_pct = 38;
        recv_gap_pct = 88;
      end else if (phase < 4) begin
        send_gap_pct = 88;
        recv_gap_pct = 38;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      await_idle();
      set_reg(npcs_pkg::RegPaletteCount, cfg_count);
      set_reg(npcs_pkg::RegUseAlpha, {{(CountW-1){1'b0}}, cfg_alpha});
      if (phase == HoldPhase) hold_request = 1'b1;
      words = (phase == HoldPhase) ? HoldWords : PhaseWords;
      for (int unsigned k = 0; k < words; k++) begin
        if ($urandom_range(99) < 20) begin
          if ($urandom_range(3) == 0) pix = palette_shadow[$urandom_range(255)];
          else pix = npcs_pkg::rgba_t'($urandom());
          push_word(npcs_pkg::OpWrite, IdxW'($urandom_range(255)), pix, 1'b0, '0);
        end else begin
          if ($urandom_range(1) == 0) begin
            pix = npcs_pkg::rgba_t'(palette_shadow[$urandom_range(searched_entries() - 1)]
                                    ^ ($urandom() & 32'h0303_0303));
          end else begin
            pix = npcs_pkg::rgba_t'($urandom());
          end
          push_word(npcs_pkg::OpMap, IdxW'($urandom_range(255)), pix, 1'b0, '0);
        end
      end
    end

    await_idle();
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
